// ----- hw/rtl/wpf_pkg.sv -----
// ----------------------------------------------------------------------------
// wpf_pkg
// Shared widths, constants and types of the windowed peak finder.
// ----------------------------------------------------------------------------
package wpf_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int POS_W      = 16;
  localparam int CNT_W      = 6;
  localparam int MAIN_W     = 17;
  localparam int HW_W       = 4;
  localparam int THR_W      = 17;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;

  localparam int MAX_HALF_WIDTH_DEF = 15;
  localparam int MAX_PEAKS          = 32;
  localparam int MAX_LENGTH         = 65536;

  localparam logic [HW_W-1:0]         HALF_WIDTH_RST = 4'd2;
  localparam logic signed [THR_W-1:0] HEIGHT_THR_RST = 17'sd32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HALF_WIDTH = 1'b0,
    CFG_HEIGHT_THR = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_CHECK,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT_PEAK,
    ST_EMIT_SUM
  } wpf_state_t;

  typedef struct packed {
    logic accept;
    logic fetch;
    logic check;
    logic scan;
    logic decide;
    logic load_peak;
    logic load_sum;
  } wpf_cmd_t;

  typedef struct packed {
    logic accept_test;
    logic in_last;
    logic chan_last;
    logic rise_ok;
    logic scan_last;
    logic peak_ok;
    logic out_free;
  } wpf_status_t;

endpackage

// ----- hw/rtl/wpf_in_if.sv -----
// ----------------------------------------------------------------------------
// wpf_in_if
// Sample stream channel: valid/ready handshake with one sample per beat.
// ----------------------------------------------------------------------------
interface wpf_in_if import wpf_pkg::*; ();

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last_sample;

  modport source (output valid, sample, last_sample, input ready);
  modport sink   (input valid, sample, last_sample, output ready);

endinterface

// ----- hw/rtl/wpf_out_if.sv -----
// ----------------------------------------------------------------------------
// wpf_out_if
// Result channel: valid/ready handshake with one peak or summary per beat.
// ----------------------------------------------------------------------------
interface wpf_out_if import wpf_pkg::*; ();

  logic                     valid;
  logic                     ready;
  logic                     is_summary;
  logic [POS_W-1:0]         peak_index;
  logic [CNT_W-1:0]         peak_count;
  logic signed [MAIN_W-1:0] main_index;
  logic                     last_of_run;

  modport source (output valid, is_summary, peak_index, peak_count, main_index,
                  last_of_run, input ready);
  modport sink   (input valid, is_summary, peak_index, peak_count, main_index,
                  last_of_run, output ready);

endinterface

// ----- hw/rtl/wpf_ctrl.sv -----
// ----------------------------------------------------------------------------
// wpf_ctrl
// Sequencer: accepts a sample, walks the window test and emits the results.
// ----------------------------------------------------------------------------
module wpf_ctrl import wpf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  wpf_status_t status,
  output wpf_cmd_t    cmd
);

  wpf_state_t state_r;
  wpf_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (status.accept_test) begin
            state_nxt = ST_FETCH;
          end else if (status.in_last) begin
            state_nxt = ST_EMIT_SUM;
          end
        end
      end
      ST_FETCH: begin
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (status.rise_ok) begin
          state_nxt = ST_SCAN;
        end else begin
          state_nxt = status.chan_last ? ST_EMIT_SUM : ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (status.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (status.peak_ok) begin
          state_nxt = ST_EMIT_PEAK;
        end else begin
          state_nxt = status.chan_last ? ST_EMIT_SUM : ST_IDLE;
        end
      end
      ST_EMIT_PEAK: begin
        if (status.out_free) begin
          state_nxt = status.chan_last ? ST_EMIT_SUM : ST_IDLE;
        end
      end
      ST_EMIT_SUM: begin
        if (status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready      = (state_r == ST_IDLE);
    cmd           = '0;
    cmd.accept    = (state_r == ST_IDLE) && in_valid;
    cmd.fetch     = (state_r == ST_FETCH);
    cmd.check     = (state_r == ST_CHECK);
    cmd.scan      = (state_r == ST_SCAN);
    cmd.decide    = (state_r == ST_DRAIN);
    cmd.load_peak = (state_r == ST_EMIT_PEAK) && status.out_free;
    cmd.load_sum  = (state_r == ST_EMIT_SUM) && status.out_free;
  end

endmodule

// ----- hw/rtl/wpf_datapath.sv -----
// ----------------------------------------------------------------------------
// wpf_datapath
// Sample window memory, channel counters, configuration and result register.
// ----------------------------------------------------------------------------
module wpf_datapath import wpf_pkg::*; #(
  parameter int MAX_HALF_WIDTH = MAX_HALF_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  wpf_cmd_t                   cmd,
  output wpf_status_t                status,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       in_last_sample,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_is_summary,
  output logic [POS_W-1:0]           out_peak_index,
  output logic [CNT_W-1:0]           out_peak_count,
  output logic signed [MAIN_W-1:0]   out_main_index,
  output logic                       out_last_of_run
);

  localparam int WIN_DEPTH = 2 * MAX_HALF_WIDTH + 3;
  localparam int AW        = $clog2(WIN_DEPTH);
  localparam int MEM_DEPTH = 1 << AW;
  localparam int NW        = $clog2(MAX_HALF_WIDTH + 1);
  localparam int HWX       = (HW_W > NW) ? HW_W : NW;
  localparam int DW        = SAMPLE_W + 2;

  // Configuration registers.
  logic [HW_W-1:0]         half_width_r;
  logic signed [THR_W-1:0] height_thr_r;

  // Channel state.
  logic [POS_W-1:0]           pos_r;
  logic [CNT_W-1:0]           peaks_r;
  logic signed [SAMPLE_W-1:0] best_val_r;
  logic signed [MAIN_W-1:0]   best_pos_r;

  // Per-sample working registers.
  logic [AW-1:0]              head_r;
  logic [NW-1:0]              n_r;
  logic [POS_W-1:0]           p_r;
  logic                       last_r;
  logic signed [SAMPLE_W-1:0] after_r;
  logic signed [SAMPLE_W-1:0] c_r;
  logic [AW-1:0]              j_r;
  logic                       cmp_valid_r;
  logic                       greater_r;

  logic signed [SAMPLE_W-1:0] win_mem [MEM_DEPTH];
  logic signed [SAMPLE_W-1:0] rd0_r;
  logic signed [SAMPLE_W-1:0] rd1_r;

  // Result register.
  logic                     out_valid_r;
  logic                     out_is_summary_r;
  logic [POS_W-1:0]         out_peak_index_r;
  logic [CNT_W-1:0]         out_peak_count_r;
  logic signed [MAIN_W-1:0] out_main_index_r;
  logic                     out_last_r;

  logic [HWX-1:0]           hw_ext;
  logic [HWX-1:0]           n_clamped;
  logic [NW-1:0]            n_live;
  logic [AW-1:0]            span_live;
  logic [AW-1:0]            head_nxt;
  logic [AW-1:0]            off1;
  logic [AW-1:0]            off2;
  logic [AW-1:0]            scan_end;
  logic [AW-1:0]            addr0;
  logic [AW-1:0]            addr1;
  logic signed [DW-1:0]     diff_before;
  logic signed [DW-1:0]     diff_after;
  logic signed [DW-1:0]     thr_ext;
  logic                     greater_hit;
  logic                     peak_ok;
  logic [POS_W-1:0]         centre_idx;

  // The half-width in force is clamped to what the window can hold.
  always_comb begin
    hw_ext    = HWX'(half_width_r);
    n_clamped = (hw_ext > HWX'(MAX_HALF_WIDTH)) ? HWX'(MAX_HALF_WIDTH) : hw_ext;
    n_live    = NW'(n_clamped);
    span_live = AW'({n_live, 1'b0}) + AW'(2);
  end

  assign head_nxt    = head_r + AW'(1);
  assign off1        = AW'(n_r) + AW'(1);
  assign off2        = AW'({n_r, 1'b0}) + AW'(2);
  assign scan_end    = AW'({n_r, 1'b0}) + AW'(1);
  assign addr0       = cmd.fetch ? (head_r - off1) : (head_r - j_r);
  assign addr1       = head_r - off2;
  assign diff_before = DW'(rd0_r) - DW'(rd1_r);
  assign diff_after  = DW'(rd0_r) - DW'(after_r);
  assign thr_ext     = DW'(height_thr_r);
  assign greater_hit = cmp_valid_r && (rd0_r > c_r);
  assign peak_ok     = !(greater_r || greater_hit);
  assign centre_idx  = p_r - (POS_W'(n_r) + POS_W'(1));

  always_comb begin
    status             = '0;
    status.accept_test = (POS_W'(span_live) <= pos_r) && (peaks_r < CNT_W'(MAX_PEAKS));
    status.in_last     = in_last_sample;
    status.chan_last   = last_r;
    status.rise_ok     = (diff_before > thr_ext) && (diff_after > thr_ext);
    status.scan_last   = (j_r == scan_end);
    status.peak_ok     = peak_ok;
    status.out_free    = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_width_r <= HALF_WIDTH_RST;
      height_thr_r <= HEIGHT_THR_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_HALF_WIDTH: half_width_r <= cfg_data[HW_W-1:0];
        CFG_HEIGHT_THR: height_thr_r <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // The newest sample sits at head_r; older ones lie behind it. Entries are
  // only read once this channel has written them, so no clearing is needed.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      win_mem[head_nxt] <= in_sample;
    end
    rd0_r <= win_mem[addr0];
    rd1_r <= win_mem[addr1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
    end else if (cmd.accept) begin
      head_r <= head_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      n_r     <= n_live;
      p_r     <= pos_r;
      after_r <= in_sample;
    end
    if (cmd.check) begin
      c_r <= rd0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r      <= 1'b0;
      j_r         <= '0;
      cmp_valid_r <= 1'b0;
      greater_r   <= 1'b0;
    end else begin
      if (cmd.accept) begin
        last_r <= in_last_sample;
      end
      if (cmd.check) begin
        j_r         <= AW'(1);
        cmp_valid_r <= 1'b0;
        greater_r   <= 1'b0;
      end else if (cmd.scan) begin
        j_r         <= j_r + AW'(1);
        cmp_valid_r <= 1'b1;
        greater_r   <= greater_r | greater_hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      peaks_r    <= '0;
      best_val_r <= '0;
      best_pos_r <= '1;
    end else begin
      if (cmd.accept) begin
        if (in_last_sample) begin
          pos_r <= '0;
        end else if (pos_r != POS_W'(MAX_LENGTH - 1)) begin
          pos_r <= pos_r + POS_W'(1);
        end
      end
      if (cmd.decide && peak_ok) begin
        peaks_r <= peaks_r + CNT_W'(1);
        if (c_r > best_val_r) begin
          best_val_r <= c_r;
          best_pos_r <= MAIN_W'(centre_idx);
        end
      end
      if (cmd.load_sum) begin
        peaks_r    <= '0;
        best_val_r <= '0;
        best_pos_r <= '1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_peak || cmd.load_sum) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_peak) begin
      out_is_summary_r <= 1'b0;
      out_peak_index_r <= centre_idx;
      out_peak_count_r <= '0;
      out_main_index_r <= '0;
      out_last_r       <= !last_r;
    end else if (cmd.load_sum) begin
      out_is_summary_r <= 1'b1;
      out_peak_index_r <= '0;
      out_peak_count_r <= peaks_r;
      out_main_index_r <= best_pos_r;
      out_last_r       <= 1'b1;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_is_summary  = out_is_summary_r;
  assign out_peak_index  = out_peak_index_r;
  assign out_peak_count  = out_peak_count_r;
  assign out_main_index  = out_main_index_r;
  assign out_last_of_run = out_last_r;

  a_peak_limit: assert property (@(posedge clk) disable iff (!rst_n)
    peaks_r <= CNT_W'(MAX_PEAKS))
    else $error("peak count passed its limit");

  a_peak_counted: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.decide && peak_ok) |=> (peaks_r == $past(peaks_r) + CNT_W'(1)))
    else $error("accepted peak was not counted");

  a_summary_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_sum |=> (peaks_r == '0) && (best_pos_r == '1))
    else $error("channel state not cleared after summary");

  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan |-> (j_r != '0) && (j_r <= scan_end))
    else $error("scan offset left the window");

  a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one command at once");

endmodule

// ----- hw/rtl/windowed_peak_finder.sv -----
// ----------------------------------------------------------------------------
// windowed_peak_finder
// Sliding-window peak detector with per-channel peak list and summary.
// ----------------------------------------------------------------------------
//  channel   direction  payload                                       beat
//  in_ch     sink       sample, last_sample                           one sample
//  out_ch    source     is_summary, peak_index, peak_count,           one result
//                       main_index, last_of_run
//  cfg_*     write      cfg_index, cfg_data (cfg_we)                  one register
//
// A sample that is not tested is taken in ST_IDLE alone; one whose rise
// test fails passes through ST_FETCH and ST_CHECK as well. A full test adds
// ST_SCAN, which walks the 2n+1 inner window samples through one read port
// of the window memory, ST_DRAIN and an emit state per result beat. Results
// wait in an output register, so a stalled out_ch holds the block only when
// a new result must be loaded. Reset is synchronous, needing no clearing pass.
module windowed_peak_finder import wpf_pkg::*; #(
  parameter int MAX_HALF_WIDTH = MAX_HALF_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  wpf_in_if.sink                in_ch,
  wpf_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  wpf_cmd_t    cmd;
  wpf_status_t status;

  wpf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  wpf_datapath #(
    .MAX_HALF_WIDTH (MAX_HALF_WIDTH)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_sample       (in_ch.sample),
    .in_last_sample  (in_ch.last_sample),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_is_summary  (out_ch.is_summary),
    .out_peak_index  (out_ch.peak_index),
    .out_peak_count  (out_ch.peak_count),
    .out_main_index  (out_ch.main_index),
    .out_last_of_run (out_ch.last_of_run)
  );

endmodule
